// ===== design/blr_pkg.sv =====
// Shared types and constants of the line rasterizer.
// No dependencies; every other design file refers to it by scoped name.
`default_nettype none

package blr_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W   = $clog2(MAX_DIM) + 1;   // holds MAX_DIM itself
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int ERR_W   = 16;
    localparam int OFFS_W  = 26;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_IDLE  = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } colour_t;

    typedef struct packed {
        colour_t            colour;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_x;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               last;
        colour_t            colour;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } pixel_t;

endpackage

`default_nettype wire

// ===== design/bresenham_line_rasterizer.sv =====
// Top level of the line rasterizer: configuration registers and stream ports.
// Depends on blr_pkg, blr_step and blr_addr.
`default_nettype none

// A start item (tuser 0) checks both endpoints against the configured image
// size and answers with the first pixel of the line, or with status 1 and
// tlast if an endpoint lies outside; each advance item (tuser 1) answers with
// the next pixel, and the final pixel of a line carries tlast. An advance with
// no line in progress answers with status 2 and zero data. Exactly one result
// comes out for every item. The block takes one item per clock, sustained,
// while the master side does not stall: each item goes through the step
// register, which holds the line state, and then the offset register behind
// the y*width multiplier, which offers the result on the master side. Widths
// above 4096 are treated as 4096, likewise heights; write the size registers
// only while no item is in flight.
module bresenham_line_rasterizer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [12:0] cfg_wdata,
    // item input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // start_x, start_y, end_x, end_y, red, green, blue
    input  wire logic [71:0] s_tdata,
    // kind
    input  wire logic        s_tuser,
    // pixel output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // pixel_x, pixel_y, element_offset, out_red, out_green, out_blue, zero pad
    output logic [79:0]      m_tdata,
    // last_pixel
    output logic             m_tlast,
    // status
    output logic [1:0]       m_tuser
);

    localparam int DW = blr_pkg::DIM_W;

    logic [DW-1:0]              width_reg, height_reg;
    logic [DW-1:0]              eff_width, eff_height;
    blr_pkg::request_t          req;
    logic                       pix_valid, pix_ready;
    blr_pkg::pixel_t            pix;
    blr_pkg::pixel_t            out_pix;
    logic [blr_pkg::OFFS_W-1:0] out_offset;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DW'(blr_pkg::MAX_DIM);
            height_reg <= DW'(blr_pkg::MAX_DIM);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                blr_pkg::CFG_WIDTH:  width_reg  <= cfg_wdata[DW-1:0];
                blr_pkg::CFG_HEIGHT: height_reg <= cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    // clamp to the largest supported image
    assign eff_width  = (width_reg  > DW'(blr_pkg::MAX_DIM)) ? DW'(blr_pkg::MAX_DIM)
                                                             : width_reg;
    assign eff_height = (height_reg > DW'(blr_pkg::MAX_DIM)) ? DW'(blr_pkg::MAX_DIM)
                                                             : height_reg;

    assign req.start_x      = s_tdata[11:0];
    assign req.start_y      = s_tdata[23:12];
    assign req.end_x        = s_tdata[35:24];
    assign req.end_y        = s_tdata[47:36];
    assign req.colour.red   = s_tdata[55:48];
    assign req.colour.green = s_tdata[63:56];
    assign req.colour.blue  = s_tdata[71:64];

    blr_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_req     (req),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix)
    );

    blr_addr u_addr (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix),
        .eff_width  (eff_width),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pix    (out_pix),
        .out_offset (out_offset)
    );

    assign m_tdata = {6'b000000, out_pix.colour.blue, out_pix.colour.green,
                      out_pix.colour.red, out_offset, out_pix.y, out_pix.x};
    assign m_tlast = out_pix.last;
    assign m_tuser = out_pix.status;

endmodule

`default_nettype wire

// ===== design/blr_step.sv =====
// Line state, Bresenham step: one item in, one record out per unstalled clock.
// Depends on blr_pkg.
`default_nettype none

module blr_step (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      in_kind,
    input  wire blr_pkg::request_t         in_req,
    input  wire logic [blr_pkg::DIM_W-1:0] eff_width,
    input  wire logic [blr_pkg::DIM_W-1:0] eff_height,
    output logic                           pix_valid,
    input  wire logic                      pix_ready,
    output blr_pkg::pixel_t                pix
);

    localparam int CW = blr_pkg::COORD_W;
    localparam int EW = blr_pkg::ERR_W;

    logic                   line_active_reg, line_active_next;
    logic [CW-1:0]          cur_x_reg, cur_x_next;
    logic [CW-1:0]          cur_y_reg, cur_y_next;
    logic [CW-1:0]          major_end_reg, major_end_next;
    logic signed [EW-1:0]   error_reg, error_next;
    logic [CW-1:0]          dmaj_reg, dmaj_next;
    logic [CW-1:0]          dmin_reg, dmin_next;
    logic                   neg_reg, neg_next;
    logic                   steep_reg, steep_next;
    blr_pkg::colour_t       colour_reg, colour_next;
    logic                   pix_valid_reg;
    blr_pkg::pixel_t        pix_reg, pix_next;

    logic                   accept;
    logic                   out_of_range;
    logic [CW-1:0]          adx, ady;
    logic                   s_steep, s_swap, s_neg;
    logic [CW-1:0]          sx0, sy0, sx1, sy1;
    logic [CW-1:0]          s_dmaj, s_dmin;
    logic signed [EW-1:0]   s_err;

    // operands of the step, from the new line or from the stored one
    logic [CW-1:0]          p_x, p_y, p_end, p_dmaj, p_dmin;
    logic signed [EW-1:0]   p_err, err_a;
    logic                   p_neg, p_steep, p_last;
    blr_pkg::colour_t       p_colour;
    logic                   do_step;

    assign in_ready  = !pix_valid_reg || pix_ready;
    assign accept    = in_valid && in_ready;
    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // set-up of a new line
    always_comb begin
        out_of_range = ({1'b0, in_req.start_x} >= eff_width)
                    || ({1'b0, in_req.end_x}   >= eff_width)
                    || ({1'b0, in_req.start_y} >= eff_height)
                    || ({1'b0, in_req.end_y}   >= eff_height);
        adx = (in_req.end_x > in_req.start_x) ? in_req.end_x - in_req.start_x
                                              : in_req.start_x - in_req.end_x;
        ady = (in_req.end_y > in_req.start_y) ? in_req.end_y - in_req.start_y
                                              : in_req.start_y - in_req.end_y;
        s_steep = !(ady < adx);
        s_swap  = s_steep ? (in_req.start_y > in_req.end_y)
                          : (in_req.start_x > in_req.end_x);
        sx0 = s_swap ? in_req.end_x   : in_req.start_x;
        sy0 = s_swap ? in_req.end_y   : in_req.start_y;
        sx1 = s_swap ? in_req.start_x : in_req.end_x;
        sy1 = s_swap ? in_req.start_y : in_req.end_y;
        if (s_steep) begin
            s_dmaj = sy1 - sy0;
            s_neg  = sx1 < sx0;
            s_dmin = s_neg ? sx0 - sx1 : sx1 - sx0;
        end else begin
            s_dmaj = sx1 - sx0;
            s_neg  = sy1 < sy0;
            s_dmin = s_neg ? sy0 - sy1 : sy1 - sy0;
        end
        s_err = $signed({3'b000, s_dmin, 1'b0}) - $signed({4'b0000, s_dmaj});
    end

    always_comb begin
        if (in_kind == blr_pkg::KIND_START) begin
            p_x      = sx0;
            p_y      = sy0;
            p_end    = s_steep ? sy1 : sx1;
            p_dmaj   = s_dmaj;
            p_dmin   = s_dmin;
            p_err    = s_err;
            p_neg    = s_neg;
            p_steep  = s_steep;
            p_colour = in_req.colour;
        end else begin
            p_x      = cur_x_reg;
            p_y      = cur_y_reg;
            p_end    = major_end_reg;
            p_dmaj   = dmaj_reg;
            p_dmin   = dmin_reg;
            p_err    = error_reg;
            p_neg    = neg_reg;
            p_steep  = steep_reg;
            p_colour = colour_reg;
        end
        p_last = (p_steep ? p_y : p_x) == p_end;
    end

    always_comb begin
        line_active_next = line_active_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        error_next       = error_reg;
        dmaj_next        = dmaj_reg;
        dmin_next        = dmin_reg;
        neg_next         = neg_reg;
        steep_next       = steep_reg;
        colour_next      = colour_reg;
        pix_next         = '0;
        do_step          = 1'b0;
        err_a            = p_err;

        if (in_kind == blr_pkg::KIND_START) begin
            if (out_of_range) begin
                line_active_next = 1'b0;
                pix_next.status  = blr_pkg::STATUS_RANGE;
                pix_next.last    = 1'b1;
            end else begin
                do_step        = 1'b1;
                major_end_next = p_end;
                dmaj_next      = p_dmaj;
                dmin_next      = p_dmin;
                neg_next       = p_neg;
                steep_next     = p_steep;
                colour_next    = p_colour;
            end
        end else if (!line_active_reg) begin
            pix_next.status = blr_pkg::STATUS_IDLE;
        end else begin
            do_step = 1'b1;
        end

        if (do_step) begin
            pix_next.x      = p_x;
            pix_next.y      = p_y;
            pix_next.colour = p_colour;
            pix_next.last   = p_last;
            pix_next.status = blr_pkg::STATUS_OK;
            line_active_next = !p_last;
            cur_x_next = p_x;
            cur_y_next = p_y;
            error_next = p_err;
            if (!p_last) begin
                // move the minor axis when the error has gone positive
                if (p_err > 0) begin
                    err_a = p_err - $signed({3'b000, p_dmaj, 1'b0});
                    if (p_steep) begin
                        cur_x_next = p_neg ? p_x - 1'b1 : p_x + 1'b1;
                    end else begin
                        cur_y_next = p_neg ? p_y - 1'b1 : p_y + 1'b1;
                    end
                end
                error_next = err_a + $signed({3'b000, p_dmin, 1'b0});
                if (p_steep) begin
                    cur_y_next = p_y + 1'b1;
                end else begin
                    cur_x_next = p_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
            pix_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                line_active_reg <= line_active_next;
            end
            if (in_ready) begin
                pix_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            error_reg     <= error_next;
            dmaj_reg      <= dmaj_next;
            dmin_reg      <= dmin_next;
            neg_reg       <= neg_next;
            steep_reg     <= steep_next;
            colour_reg    <= colour_next;
            pix_reg       <= pix_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/blr_addr.sv =====
// Element offset of a pixel (3*(y*width + x)) and the result register.
// Depends on blr_pkg.
`default_nettype none

module blr_addr (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      pix_valid,
    output logic                           pix_ready,
    input  wire blr_pkg::pixel_t           pix,
    input  wire logic [blr_pkg::DIM_W-1:0] eff_width,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output blr_pkg::pixel_t                out_pix,
    output logic [blr_pkg::OFFS_W-1:0]     out_offset
);

    localparam int PW = blr_pkg::COORD_W + blr_pkg::DIM_W;

    logic                          out_valid_reg;
    blr_pkg::pixel_t               out_pix_reg;
    logic [blr_pkg::OFFS_W-1:0]    offset_reg, offset_next;
    logic [PW-1:0]                 row_base;
    logic [PW-1:0]                 linear;

    assign pix_ready  = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_pix    = out_pix_reg;
    assign out_offset = offset_reg;

    // x and y are zero on error records, so the offset comes out zero too
    always_comb begin
        row_base    = PW'(pix.y) * PW'(eff_width);
        linear      = row_base + PW'(pix.x);
        offset_next = blr_pkg::OFFS_W'({linear, 1'b0} + {1'b0, linear});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pix_ready) begin
            out_valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_valid && pix_ready) begin
            out_pix_reg <= pix;
            offset_reg  <= offset_next;
        end
    end

endmodule

`default_nettype wire
